@@ rtl/ags_pkg.sv @@
package ags_pkg;

   localparam int VERTICES_DEFAULT = 16;

   localparam int OP_W     = 3;
   localparam int VTX_W    = 4;
   localparam int CHAR_W   = 8;
   localparam int SIZE_W   = 5;
   localparam int DEG_W    = 5;
   localparam int NBR_W    = 16;
   localparam int COUNT_W  = 5;
   localparam int EDGES_W  = 8;

   localparam int G6_BIAS    = 63;
   localparam int PAIR_STEPS = 6;
   localparam int CNT_MAX    = 31;
   localparam int EC_MAX     = 255;

   localparam logic [OP_W-1:0] OP_ADD_EDGE   = 3'd0;
   localparam logic [OP_W-1:0] OP_DEL_EDGE   = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD_VERTEX = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_VERTEX = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;
   localparam logic [OP_W-1:0] OP_G6_HEADER  = 3'd5;
   localparam logic [OP_W-1:0] OP_G6_DATA    = 3'd6;
   localparam logic [OP_W-1:0] OP_MAKE_CYCLE = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [VTX_W-1:0]  first_vertex;
      logic [VTX_W-1:0]  second_vertex;
      logic [CHAR_W-1:0] code_char;
      logic [SIZE_W-1:0] cycle_size;
   } cmd_type;

   typedef struct packed {
      logic               edge_present;
      logic               vertex_present;
      logic [DEG_W-1:0]   row_degree;
      logic [NBR_W-1:0]   neighbour_mask;
      logic [COUNT_W-1:0] vertex_count;
      logic [EDGES_W-1:0] edge_count;
      logic               size_error;
   } result_type;

endpackage

@@ rtl/ags_if.sv @@
interface ags_req_if;
   logic                          valid;
   logic                          ready;
   logic [ags_pkg::OP_W-1:0]      op;
   logic [ags_pkg::VTX_W-1:0]     first_vertex;
   logic [ags_pkg::VTX_W-1:0]     second_vertex;
   logic [ags_pkg::CHAR_W-1:0]    code_char;
   logic [ags_pkg::SIZE_W-1:0]    cycle_size;

   modport source (output valid, output op, output first_vertex, output second_vertex,
                   output code_char, output cycle_size, input ready);
   modport sink   (input valid, input op, input first_vertex, input second_vertex,
                   input code_char, input cycle_size, output ready);
endinterface

interface ags_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          edge_present;
   logic                          vertex_present;
   logic [ags_pkg::DEG_W-1:0]     row_degree;
   logic [ags_pkg::NBR_W-1:0]     neighbour_mask;
   logic [ags_pkg::COUNT_W-1:0]   vertex_count;
   logic [ags_pkg::EDGES_W-1:0]   edge_count;
   logic                          size_error;

   modport source (output valid, output edge_present, output vertex_present,
                   output row_degree, output neighbour_mask, output vertex_count,
                   output edge_count, output size_error, input ready);
   modport sink   (input valid, input edge_present, input vertex_present,
                   input row_degree, input neighbour_mask, input vertex_count,
                   input edge_count, input size_error, output ready);
endinterface

@@ rtl/ags_engine.sv @@
module ags_engine #(
   parameter int VERTICES = ags_pkg::VERTICES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ags_pkg::cmd_type    in_cmd,
   output logic                res_valid,
   input  logic                res_ready,
   output ags_pkg::result_type res
);
   import ags_pkg::*;

   localparam int RW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int CW = $clog2(VERTICES + 1);
   localparam int TW = $clog2(VERTICES * VERTICES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PAIR  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   function automatic logic [CW-1:0] popcnt(input logic [VERTICES-1:0] x);
      logic [CW-1:0] c;
      c = '0;
      for (int j = 0; j < VERTICES; j++) begin
         c = c + CW'(x[j]);
      end
      return c;
   endfunction

   logic [1:0]          state_ff, state_in;
   cmd_type             cmd_ff;
   logic [VERTICES-1:0] mask_ff, mask_in;
   logic [CW-1:0]       load_total_ff, load_total_in;
   logic [RW-1:0]       load_row_ff, load_row_in;
   logic [CW-1:0]       load_col_ff, load_col_in;
   logic                load_active_ff, load_active_in;
   logic                size_err_ff, size_err_in;
   logic [2:0]          step_ff, step_in;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic                wb_valid_ff, wb_valid_in;
   logic [RW-1:0]       wb_idx_ff, wb_idx_in;

   logic [PAIR_STEPS-1:0] pair_on_ff;
   logic [RW-1:0]         pair_row_ff [PAIR_STEPS];
   logic [RW-1:0]         pair_col_ff [PAIR_STEPS];

   logic [VERTICES-1:0] row_mem_ff [VERTICES];
   logic [VERTICES-1:0] row_valid_ff;
   logic [VERTICES-1:0] rd_data_ff;
   logic                rd_live_ff;
   logic [RW-1:0]       rd_addr;

   logic [TW-1:0]       total_ff;
   logic [CW-1:0]       vc_ff;
   logic [CW-1:0]       deg_ff;
   logic [VERTICES-1:0] row_u_ff;

   logic                accept;
   logic                a_u_ok;
   logic [RW-1:0]       a_u_idx;
   logic [CHAR_W-1:0]   hdr_diff;
   logic                hdr_ge;
   logic [CW-1:0]       hdr_n;
   logic                cyc_err;

   logic [CHAR_W-1:0]   data_diff;
   logic [2:0]          bit_sel;
   logic                rec_on;
   logic [CW-1:0]       row_next;
   logic [CW-1:0]       col_next;
   logic                rd_en;

   logic                u_ok, v_ok;
   logic [RW-1:0]       u_idx, v_idx;
   logic [VERTICES-1:0] old_row, new_row;
   logic [RW-1:0]       nxt_idx, prv_idx;
   logic [CW-1:0]       new_cnt;

   logic                vp;
   logic [VERTICES-1:0] row_out;
   logic [TW-1:0]       half_total;

   assign accept   = in_valid && in_ready;
   assign in_ready = (state_ff == ST_IDLE);
   assign rd_addr  = rd_idx_ff[RW-1:0];
   assign rd_en    = (32'(rd_idx_ff) < VERTICES);

   assign a_u_ok   = (32'(in_cmd.first_vertex) < VERTICES);
   assign a_u_idx  = RW'(in_cmd.first_vertex);
   assign hdr_diff = in_cmd.code_char - CHAR_W'(G6_BIAS);
   assign hdr_ge   = (32'(in_cmd.code_char) >= G6_BIAS);
   assign cyc_err  = (32'(in_cmd.cycle_size) > VERTICES);

   always_comb begin
      if (!hdr_ge) begin
         hdr_n = '0;
      end else if (32'(hdr_diff) > VERTICES) begin
         hdr_n = CW'(VERTICES);
      end else begin
         hdr_n = CW'(hdr_diff);
      end
   end

   assign data_diff = cmd_ff.code_char - CHAR_W'(G6_BIAS);
   assign bit_sel   = 3'(PAIR_STEPS - 1) - step_ff;
   assign rec_on    = load_active_ff && data_diff[bit_sel];
   assign row_next  = CW'(load_row_ff) + CW'(1);
   assign col_next  = load_col_ff + CW'(1);

   always_comb begin
      state_in       = state_ff;
      mask_in        = mask_ff;
      load_total_in  = load_total_ff;
      load_row_in    = load_row_ff;
      load_col_in    = load_col_ff;
      load_active_in = load_active_ff;
      size_err_in    = size_err_ff;
      step_in        = step_ff;
      rd_idx_in      = rd_idx_ff;
      wb_valid_in    = 1'b0;
      wb_idx_in      = wb_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in     = '0;
               rd_idx_in   = '0;
               size_err_in = (in_cmd.op == OP_MAKE_CYCLE) && cyc_err;
               case (in_cmd.op)
                  OP_ADD_VERTEX: begin
                     if (a_u_ok) begin
                        mask_in[a_u_idx] = 1'b1;
                     end
                  end
                  OP_DEL_VERTEX: begin
                     if (a_u_ok) begin
                        mask_in[a_u_idx] = 1'b0;
                     end
                  end
                  OP_G6_HEADER: begin
                     for (int j = 0; j < VERTICES; j++) begin
                        mask_in[j] = (j < int'(hdr_n));
                     end
                     load_total_in  = hdr_n;
                     load_row_in    = '0;
                     load_col_in    = hdr_ge ? CW'(1) : '0;
                     load_active_in = (32'(hdr_n) >= 2);
                  end
                  OP_MAKE_CYCLE: begin
                     if (!cyc_err) begin
                        for (int j = 0; j < VERTICES; j++) begin
                           mask_in[j] = (j < int'(in_cmd.cycle_size));
                        end
                        load_total_in  = '0;
                        load_row_in    = '0;
                        load_col_in    = '0;
                        load_active_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
               if ((in_cmd.op == OP_G6_DATA) && load_active_ff) begin
                  state_in = ST_PAIR;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_PAIR: begin
            if (load_active_ff) begin
               if (row_next >= load_col_ff) begin
                  load_row_in = '0;
                  load_col_in = col_next;
                  if (col_next >= load_total_ff) begin
                     load_active_in = 1'b0;
                  end
               end else begin
                  load_row_in = RW'(row_next);
               end
            end
            if (step_ff == 3'(PAIR_STEPS - 1)) begin
               state_in = ST_SWEEP;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_SWEEP: begin
            if (rd_en) begin
               rd_idx_in   = rd_idx_ff + CW'(1);
               wb_valid_in = 1'b1;
               wb_idx_in   = rd_addr;
            end else if (wb_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign u_ok  = (32'(cmd_ff.first_vertex) < VERTICES);
   assign v_ok  = (32'(cmd_ff.second_vertex) < VERTICES);
   assign u_idx = RW'(cmd_ff.first_vertex);
   assign v_idx = RW'(cmd_ff.second_vertex);

   assign old_row = rd_live_ff ? rd_data_ff : '0;
   assign nxt_idx = (32'(wb_idx_ff) + 1 == 32'(cmd_ff.cycle_size)) ? '0 : wb_idx_ff + RW'(1);
   assign prv_idx = (wb_idx_ff == '0) ? RW'(cmd_ff.cycle_size - SIZE_W'(1))
                                      : wb_idx_ff - RW'(1);

   always_comb begin
      new_row = old_row;
      case (cmd_ff.op)
         OP_ADD_EDGE: begin
            if (u_ok && v_ok) begin
               if (wb_idx_ff == u_idx) begin
                  new_row[v_idx] = 1'b1;
               end
               if (wb_idx_ff == v_idx) begin
                  new_row[u_idx] = 1'b1;
               end
            end
         end
         OP_DEL_EDGE: begin
            if (u_ok && v_ok) begin
               if (wb_idx_ff == u_idx) begin
                  new_row[v_idx] = 1'b0;
               end
               if (wb_idx_ff == v_idx) begin
                  new_row[u_idx] = 1'b0;
               end
            end
         end
         OP_DEL_VERTEX: begin
            if (u_ok) begin
               if (wb_idx_ff == u_idx) begin
                  new_row = '0;
               end
               new_row[u_idx] = 1'b0;
            end
         end
         OP_G6_HEADER: begin
            new_row = '0;
         end
         OP_G6_DATA: begin
            for (int k = 0; k < PAIR_STEPS; k++) begin
               if (pair_on_ff[k]) begin
                  if (pair_row_ff[k] == wb_idx_ff) begin
                     new_row[pair_col_ff[k]] = 1'b1;
                  end
                  if (pair_col_ff[k] == wb_idx_ff) begin
                     new_row[pair_row_ff[k]] = 1'b1;
                  end
               end
            end
         end
         OP_MAKE_CYCLE: begin
            if (!size_err_ff) begin
               new_row = '0;
               if (32'(wb_idx_ff) < 32'(cmd_ff.cycle_size)) begin
                  if (cmd_ff.cycle_size >= SIZE_W'(2)) begin
                     new_row[nxt_idx] = 1'b1;
                  end
                  if (cmd_ff.cycle_size > SIZE_W'(2)) begin
                     new_row[prv_idx] = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign new_cnt = popcnt(new_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mask_ff        <= '0;
         load_total_ff  <= '0;
         load_row_ff    <= '0;
         load_col_ff    <= '0;
         load_active_ff <= 1'b0;
         size_err_ff    <= 1'b0;
         step_ff        <= '0;
         rd_idx_ff      <= '0;
         wb_valid_ff    <= 1'b0;
         wb_idx_ff      <= '0;
         pair_on_ff     <= '0;
         row_valid_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         mask_ff        <= mask_in;
         load_total_ff  <= load_total_in;
         load_row_ff    <= load_row_in;
         load_col_ff    <= load_col_in;
         load_active_ff <= load_active_in;
         size_err_ff    <= size_err_in;
         step_ff        <= step_in;
         rd_idx_ff      <= rd_idx_in;
         wb_valid_ff    <= wb_valid_in;
         wb_idx_ff      <= wb_idx_in;
         if (accept) begin
            pair_on_ff <= '0;
         end else if (state_ff == ST_PAIR) begin
            pair_on_ff[step_ff] <= rec_on;
         end
         if (wb_valid_ff) begin
            row_valid_ff[wb_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= in_cmd;
         total_ff <= '0;
         vc_ff    <= '0;
         deg_ff   <= '0;
         row_u_ff <= '0;
      end
      if (state_ff == ST_PAIR) begin
         pair_row_ff[step_ff] <= load_row_ff;
         pair_col_ff[step_ff] <= RW'(load_col_ff);
      end
      if (wb_valid_ff) begin
         total_ff <= total_ff + TW'(new_cnt);
         vc_ff    <= vc_ff + CW'(mask_ff[wb_idx_ff]);
         if (u_ok && (wb_idx_ff == u_idx)) begin
            row_u_ff <= new_row;
            deg_ff   <= new_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wb_valid_ff) begin
         row_mem_ff[wb_idx_ff] <= new_row;
      end
      rd_data_ff <= row_mem_ff[rd_addr];
      rd_live_ff <= row_valid_ff[rd_addr];
   end

   assign vp         = u_ok && mask_ff[u_idx];
   assign row_out    = vp ? row_u_ff : '0;
   assign half_total = total_ff >> 1;

   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res.edge_present   = u_ok && v_ok && row_u_ff[v_idx];
      res.vertex_present = vp;
      if (!vp) begin
         res.row_degree = '0;
      end else if (32'(deg_ff) > CNT_MAX) begin
         res.row_degree = DEG_W'(CNT_MAX);
      end else begin
         res.row_degree = DEG_W'(deg_ff);
      end
      res.neighbour_mask = NBR_W'(row_out);
      if (32'(vc_ff) > CNT_MAX) begin
         res.vertex_count = COUNT_W'(CNT_MAX);
      end else begin
         res.vertex_count = COUNT_W'(vc_ff);
      end
      if (32'(half_total) > EC_MAX) begin
         res.edge_count = EDGES_W'(EC_MAX);
      end else begin
         res.edge_count = EDGES_W'(half_total);
      end
      res.size_error = size_err_ff;
   end

endmodule

@@ rtl/adjacency_matrix_graph_store.sv @@
// Channel   Direction  Beat contents
// req_bus   in         op, first_vertex, second_vertex, code_char, cycle_size
// rsp_bus   out        edge_present, vertex_present, row_degree, neighbour_mask,
//                      vertex_count, edge_count, size_error
//
// A beat's result reaches the output register after the row sweep, and the next beat is
// taken once the engine has handed it on; a graph6 data character is decoded first when loading.
// In the row sweep one matrix row is read, updated and counted per cycle.
// Reset clears the vertex mask, the load state and the row valid bits.
// req_bus.ready is low while a beat is in work; a held result does not stall the next beat
// until that beat's own result is ready.
module adjacency_matrix_graph_store #(
   parameter int VERTICES = ags_pkg::VERTICES_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   ags_req_if.sink  req_bus,
   ags_rsp_if.source rsp_bus
);
   import ags_pkg::*;

   cmd_type    cmd;
   result_type eng_res;
   logic       eng_res_valid;
   logic       eng_res_ready;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   assign cmd.op            = req_bus.op;
   assign cmd.first_vertex  = req_bus.first_vertex;
   assign cmd.second_vertex = req_bus.second_vertex;
   assign cmd.code_char     = req_bus.code_char;
   assign cmd.cycle_size    = req_bus.cycle_size;

   ags_engine #(
      .VERTICES(VERTICES)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .in_cmd   (cmd),
      .res_valid(eng_res_valid),
      .res_ready(eng_res_ready),
      .res      (eng_res)
   );

   assign eng_res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eng_res_valid && eng_res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res_valid && eng_res_ready) begin
         rsp_data_ff <= eng_res;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.edge_present   = rsp_data_ff.edge_present;
   assign rsp_bus.vertex_present = rsp_data_ff.vertex_present;
   assign rsp_bus.row_degree     = rsp_data_ff.row_degree;
   assign rsp_bus.neighbour_mask = rsp_data_ff.neighbour_mask;
   assign rsp_bus.vertex_count   = rsp_data_ff.vertex_count;
   assign rsp_bus.edge_count     = rsp_data_ff.edge_count;
   assign rsp_bus.size_error     = rsp_data_ff.size_error;

endmodule

@@ sim/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ags_pkg::*;

   localparam int GRAPH_SIZE  = VERTICES_DEFAULT;
   localparam int SETTLE      = GRAPH_SIZE + 3 + PAIR_STEPS + 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 440;

   class graph_mirror;
      logic [GRAPH_SIZE-1:0] present;
      logic [GRAPH_SIZE-1:0] rows [GRAPH_SIZE];
      int         load_total;
      int         load_row;
      int         load_col;
      bit         load_on;
      result_type expected_results [$];
      int         mismatches;
      int         checked;
      int         op_tally [8];
      int         size_errors;

      function void wipe();
         present = '0;
         foreach (rows[i]) rows[i] = '0;
         load_total = 0;
         load_row = 0;
         load_col = 0;
         load_on = 1'b0;
      endfunction

      function void link(int a, int b);
         rows[a][b] = 1'b1;
         rows[b][a] = 1'b1;
      endfunction

      function result_type predict_result(cmd_type c);
         result_type r;
         int u;
         int v;
         int n;
         int total;
         logic [CHAR_W-1:0] bits;
         u = c.first_vertex;
         v = c.second_vertex;
         r = '0;
         case (c.op)
            OP_ADD_EDGE: link(u, v);
            OP_DEL_EDGE: begin
               rows[u][v] = 1'b0;
               rows[v][u] = 1'b0;
            end
            OP_ADD_VERTEX: present[u] = 1'b1;
            OP_DEL_VERTEX: begin
               present[u] = 1'b0;
               rows[u] = '0;
               foreach (rows[i]) rows[i][u] = 1'b0;
            end
            OP_QUERY: ;
            OP_G6_HEADER: begin
               wipe();
               if (c.code_char >= G6_BIAS) begin
                  n = c.code_char - G6_BIAS;
                  if (n > GRAPH_SIZE) n = GRAPH_SIZE;
                  for (int i = 0; i < n; i++) present[i] = 1'b1;
                  load_total = n;
                  load_row = 0;
                  load_col = 1;
                  load_on = (n >= 2);
               end
            end
            OP_G6_DATA: begin
               if (load_on) begin
                  bits = c.code_char - CHAR_W'(G6_BIAS);
                  for (int p = PAIR_STEPS - 1; p >= 0 && load_on; p--) begin
                     if (bits[p]) link(load_row, load_col);
                     load_row++;
                     if (load_row >= load_col) begin
                        load_row = 0;
                        load_col++;
                        if (load_col >= load_total) load_on = 1'b0;
                     end
                  end
               end
            end
            OP_MAKE_CYCLE: begin
               if (c.cycle_size > GRAPH_SIZE) begin
                  r.size_error = 1'b1;
                  size_errors++;
               end else begin
                  wipe();
                  n = c.cycle_size;
                  for (int i = 0; i < n; i++) present[i] = 1'b1;
                  if (n > 2) begin
                     for (int i = 0; i < n; i++) link(i, (i + 1) % n);
                  end else if (n == 2) begin
                     link(0, 1);
                  end
               end
            end
         endcase
         r.vertex_present = present[u];
         r.edge_present   = rows[u][v];
         r.neighbour_mask = present[u] ? rows[u] : '0;
         r.row_degree     = DEG_W'($countones(r.neighbour_mask));
         r.vertex_count   = COUNT_W'($countones(present));
         total = 0;
         foreach (rows[i]) total += $countones(rows[i]);
         r.edge_count = EDGES_W'(total / 2);
         return r;
      endfunction

      function void note_command(cmd_type c);
         op_tally[c.op]++;
         expected_results.push_back(predict_result(c));
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         checked++;
         compare_field("edge_present", want.edge_present, got.edge_present);
         compare_field("vertex_present", want.vertex_present, got.vertex_present);
         compare_field("row_degree", want.row_degree, got.row_degree);
         compare_field("neighbour_mask", want.neighbour_mask, got.neighbour_mask);
         compare_field("vertex_count", want.vertex_count, got.vertex_count);
         compare_field("edge_count", want.edge_count, got.edge_count);
         compare_field("size_error", want.size_error, got.size_error);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ags_req_if req_bus ();
   ags_rsp_if rsp_bus ();

   adjacency_matrix_graph_store dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   graph_mirror mirror = new;
   int idle_pct;
   int stall_pct;
   int commands_counted;
   int cycle_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         mirror.check_result('{rsp_bus.edge_present, rsp_bus.vertex_present,
                               rsp_bus.row_degree, rsp_bus.neighbour_mask,
                               rsp_bus.vertex_count, rsp_bus.edge_count,
                               rsp_bus.size_error});
      end
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles.", cycle_count);
      $display("FAIL");
      $finish;
   end

   function automatic cmd_type random_cmd(logic [OP_W-1:0] op);
      cmd_type c;
      c.op            = op;
      c.first_vertex  = VTX_W'($urandom_range(GRAPH_SIZE - 1));
      c.second_vertex = VTX_W'($urandom_range(GRAPH_SIZE - 1));
      c.code_char     = CHAR_W'($urandom_range(255));
      c.cycle_size    = SIZE_W'($urandom_range(31));
      return c;
   endfunction

   function automatic cmd_type shaped_cmd(logic [OP_W-1:0] op, int u, int v, int ch, int sz);
      cmd_type c;
      c.op            = op;
      c.first_vertex  = VTX_W'(u);
      c.second_vertex = VTX_W'(v);
      c.code_char     = CHAR_W'(ch);
      c.cycle_size    = SIZE_W'(sz);
      return c;
   endfunction

   task automatic send_command(cmd_type c);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      if (c.op != OP_G6_DATA || mirror.load_on) commands_counted++;
      req_bus.valid         <= 1'b1;
      req_bus.op            <= c.op;
      req_bus.first_vertex  <= c.first_vertex;
      req_bus.second_vertex <= c.second_vertex;
      req_bus.code_char     <= c.code_char;
      req_bus.cycle_size    <= c.cycle_size;
      do @(posedge clock); while (!req_bus.ready);
      mirror.note_command(c);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (mirror.expected_results.size() != 0);
   endtask

   task automatic run_directed();
      send_command(shaped_cmd(OP_QUERY, 0, 15, 0, 0));
      send_command(shaped_cmd(OP_ADD_VERTEX, 0, 0, 0, 0));
      send_command(shaped_cmd(OP_ADD_VERTEX, 15, 0, 0, 0));
      send_command(shaped_cmd(OP_ADD_EDGE, 0, 15, 255, 31));
      send_command(shaped_cmd(OP_ADD_EDGE, 5, 5, 0, 0));
      send_command(shaped_cmd(OP_ADD_EDGE, 3, 9, 0, 0));
      send_command(shaped_cmd(OP_DEL_EDGE, 15, 0, 0, 0));
      send_command(shaped_cmd(OP_ADD_EDGE, 15, 0, 0, 0));
      send_command(shaped_cmd(OP_DEL_VERTEX, 15, 0, 0, 0));
      send_command(shaped_cmd(OP_G6_DATA, 0, 15, 255, 0));
      send_command(shaped_cmd(OP_G6_HEADER, 0, 0, 0, 0));
      send_command(shaped_cmd(OP_G6_DATA, 0, 1, 126, 0));
      send_command(shaped_cmd(OP_G6_HEADER, 0, 1, 64, 0));
      send_command(shaped_cmd(OP_G6_DATA, 0, 1, 126, 0));
      send_command(shaped_cmd(OP_G6_HEADER, 0, 1, 67, 0));
      send_command(shaped_cmd(OP_G6_DATA, 0, 3, 126, 0));
      send_command(shaped_cmd(OP_G6_DATA, 1, 2, 126, 0));
      send_command(shaped_cmd(OP_QUERY, 3, 2, 0, 0));
      send_command(shaped_cmd(OP_G6_HEADER, 15, 14, 255, 0));
      send_command(shaped_cmd(OP_G6_DATA, 0, 1, 255, 0));
      send_command(shaped_cmd(OP_G6_DATA, 2, 3, 0, 0));
      send_command(shaped_cmd(OP_MAKE_CYCLE, 0, 1, 0, 0));
      send_command(shaped_cmd(OP_MAKE_CYCLE, 0, 1, 0, 2));
      send_command(shaped_cmd(OP_MAKE_CYCLE, 2, 0, 0, 3));
      send_command(shaped_cmd(OP_MAKE_CYCLE, 15, 0, 0, 16));
      send_command(shaped_cmd(OP_MAKE_CYCLE, 15, 14, 0, 17));
      send_command(shaped_cmd(OP_MAKE_CYCLE, 0, 15, 255, 31));
   endtask

   // A header followed by data characters with random content, now and then cut
   // short or padded, and then a few commands against the loaded graph.
   task automatic load_graph6();
      cmd_type c;
      int n;
      int chars;
      c = random_cmd(OP_G6_HEADER);
      if ($urandom_range(9) != 0) c.code_char = CHAR_W'(G6_BIAS + 2 + $urandom_range(14));
      send_command(c);
      n = (c.code_char < G6_BIAS) ? 0 : int'(c.code_char) - G6_BIAS;
      if (n > GRAPH_SIZE) n = GRAPH_SIZE;
      chars = (n * (n - 1) / 2 + PAIR_STEPS - 1) / PAIR_STEPS;
      case ($urandom_range(9))
         0: chars = $urandom_range(chars);
         1: chars = chars + 1 + $urandom_range(2);
         default: ;
      endcase
      for (int i = 0; i < chars; i++) begin
         c = random_cmd(OP_G6_DATA);
         if ($urandom_range(4) != 0) c.code_char = CHAR_W'(G6_BIAS + $urandom_range(63));
         send_command(c);
      end
      for (int i = $urandom_range(3); i > 0; i--) send_command(random_cmd(OP_QUERY));
   endtask

   task automatic run_random(int count);
      cmd_type c;
      int pick;
      int target;
      target = commands_counted + count;
      while (commands_counted < target) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            load_graph6();
         end else if (pick < 35) begin
            c = random_cmd(OP_MAKE_CYCLE);
            if ($urandom_range(9) != 0) c.cycle_size = SIZE_W'($urandom_range(GRAPH_SIZE));
            send_command(c);
         end else if (pick < 57) begin
            send_command(random_cmd(OP_ADD_EDGE));
         end else if (pick < 71) begin
            send_command(random_cmd(OP_DEL_EDGE));
         end else if (pick < 81) begin
            send_command(random_cmd(OP_ADD_VERTEX));
         end else if (pick < 87) begin
            send_command(random_cmd(OP_DEL_VERTEX));
         end else if (pick < 95) begin
            send_command(random_cmd(OP_QUERY));
         end else if (pick < 98) begin
            send_command(random_cmd(OP_G6_DATA));
         end else begin
            send_command(random_cmd(OP_G6_HEADER));
         end
      end
   endtask

   initial begin
      int idle_plan [4];
      int stall_plan [4];
      idle_plan  = '{0, 64, 0, 12};
      stall_plan = '{0, 0, 64, 12};
      idle_pct = 0;
      stall_pct = 0;
      commands_counted = 0;
      mirror.wipe();
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.op            <= OP_QUERY;
      req_bus.first_vertex  <= '0;
      req_bus.second_vertex <= '0;
      req_bus.code_char     <= '0;
      req_bus.cycle_size    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      for (int p = 0; p < 4; p++) begin
         drain_results();
         idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         run_random(PHASE_ITEMS);
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);
      $display("Checked %0d results from %0d effective commands in four idle/stall phases.",
               mirror.checked, commands_counted);
      $display("Headers %0d, data chars %0d, cycle builds %0d (%0d oversized).",
               mirror.op_tally[OP_G6_HEADER], mirror.op_tally[OP_G6_DATA],
               mirror.op_tally[OP_MAKE_CYCLE], mirror.size_errors);
      if (mirror.mismatches == 0 && mirror.expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
